// ===== rtl/core/rbs_pkg.sv =====
`timescale 1ns / 1ps
package rbs_pkg;

  localparam int Q_W    = 32;
  localparam int HALF_W = 31;
  localparam int NUM_W  = 34;
  // one operand stage, one stage per quotient bit, one saturation stage
  localparam int DIV_LAT = Q_W + 2;
  localparam int ADDR_W  = 5;

  localparam logic signed [Q_W-1:0] T_MIN = {1'b1, {(Q_W-1){1'b0}}};
  localparam logic signed [Q_W-1:0] T_MAX = {1'b0, {(Q_W-1){1'b1}}};

  localparam logic signed [Q_W-1:0] CENTER_RST = 32'sd32768;
  localparam logic [HALF_W-1:0]     HALF_RST   = 31'd32768;

  localparam logic [2:0] REG_CENTER_X = 3'd0;
  localparam logic [2:0] REG_CENTER_Y = 3'd1;
  localparam logic [2:0] REG_CENTER_Z = 3'd2;
  localparam logic [2:0] REG_HALF_X   = 3'd3;
  localparam logic [2:0] REG_HALF_Y   = 3'd4;
  localparam logic [2:0] REG_HALF_Z   = 3'd5;

  typedef struct packed {
    logic       par_fail;
    logic [2:0] nz;
  } side_t;

endpackage

// ===== rtl/core/rbs_if.sv =====
`timescale 1ns / 1ps
interface ray_if;
  logic valid;
  logic ready;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [31:0] origin_z;
  logic signed [31:0] dir_x;
  logic signed [31:0] dir_y;
  logic signed [31:0] dir_z;
  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                output ready);
endinterface

interface hit_if;
  logic valid;
  logic ready;
  logic hit;
  logic signed [31:0] t_near;
  logic signed [31:0] t_far;
  modport source (output valid, hit, t_near, t_far, input ready);
  modport sink (input valid, hit, t_near, t_far, output ready);
endinterface

// ===== rtl/core/ray_box_slab_intersection.sv =====
`timescale 1ns / 1ps
// An accepted ray word reaches its result word through the operand stage,
// the 34-stage divider and the combine/output stage.
// Throughput: one ray per cycle; a stalled output freezes the whole pipe.
// Six dividers, one quotient bit per stage each, set the depth.
// Reset (rst, synchronous) clears the valid bits and loads 0.5 into all box registers.
module ray_box_slab_intersection (
  input  logic                          clk,
  input  logic                          rst,
  ray_if.sink                           ray,
  hit_if.source                         res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rbs_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import rbs_pkg::*;

  logic signed [Q_W-1:0]    center [0:2];
  logic        [HALF_W-1:0] half   [0:2];

  logic en;
  logic [2:0] ridx;

  assign pready = 1'b1;
  assign ridx   = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        center[i] <= CENTER_RST;
        half[i]   <= HALF_RST;
      end
    end else if (psel && penable && pwrite) begin
      case (ridx)
        REG_CENTER_X: center[0] <= $signed(pwdata);
        REG_CENTER_Y: center[1] <= $signed(pwdata);
        REG_CENTER_Z: center[2] <= $signed(pwdata);
        REG_HALF_X:   half[0]   <= pwdata[HALF_W-1:0];
        REG_HALF_Y:   half[1]   <= pwdata[HALF_W-1:0];
        REG_HALF_Z:   half[2]   <= pwdata[HALF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_CENTER_X: prdata = center[0];
      REG_CENTER_Y: prdata = center[1];
      REG_CENTER_Z: prdata = center[2];
      REG_HALF_X:   prdata = {1'b0, half[0]};
      REG_HALF_Y:   prdata = {1'b0, half[1]};
      REG_HALF_Z:   prdata = {1'b0, half[2]};
      default:      prdata = '0;
    endcase
  end

  assign en        = !res.valid || res.ready;
  assign ray.ready = en;

  // operand stage
  logic signed [Q_W-1:0]   org [0:2];
  logic signed [Q_W-1:0]   dir [0:2];
  logic signed [Q_W:0]     d   [0:2];
  logic signed [Q_W:0]     es  [0:2];
  logic        [Q_W:0]     ad  [0:2];
  logic [2:0]              pf;
  logic [2:0]              nz;

  logic signed [NUM_W-1:0] num0 [0:2];
  logic signed [NUM_W-1:0] num1 [0:2];
  logic signed [Q_W-1:0]   den  [0:2];

  side_t side  [0:DIV_LAT];
  logic  vld   [0:DIV_LAT];

  always_comb begin
    org[0] = ray.origin_x; org[1] = ray.origin_y; org[2] = ray.origin_z;
    dir[0] = ray.dir_x;    dir[1] = ray.dir_y;    dir[2] = ray.dir_z;
    for (int i = 0; i < 3; i++) begin
      d[i]  = (Q_W+1)'(center[i]) - (Q_W+1)'(org[i]);
      es[i] = dir[i][Q_W-1] ? -$signed({2'b00, half[i]}) : $signed({2'b00, half[i]});
      ad[i] = d[i][Q_W] ? (Q_W+1)'(-d[i]) : (Q_W+1)'(d[i]);
      pf[i] = (dir[i] == '0) && (ad[i] > {2'b00, half[i]});
      nz[i] = dir[i] != '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        num0[i] <= NUM_W'(d[i]) - NUM_W'(es[i]);
        num1[i] <= NUM_W'(d[i]) + NUM_W'(es[i]);
        den[i]  <= dir[i];
      end
      side[0] <= '{par_fail: |pf, nz: nz};
      for (int k = 0; k < DIV_LAT; k++) begin
        side[k+1] <= side[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= DIV_LAT; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= ray.valid;
      for (int k = 0; k < DIV_LAT; k++) vld[k+1] <= vld[k];
    end
  end

  logic signed [Q_W-1:0] qn [0:2];
  logic signed [Q_W-1:0] qf [0:2];

  for (genvar g = 0; g < 3; g++) begin : g_axis
    rbs_div u_near (.clk(clk), .en(en), .num(num0[g]), .den(den[g]), .q(qn[g]));
    rbs_div u_far  (.clk(clk), .en(en), .num(num1[g]), .den(den[g]), .q(qf[g]));
  end

  // combine: interval over nonparallel axes
  logic signed [Q_W-1:0] lo, hi;
  logic                  ok;
  side_t                 sd;

  always_comb begin
    sd = side[DIV_LAT];
    lo = T_MIN;
    hi = T_MAX;
    for (int i = 0; i < 3; i++) begin
      if (sd.nz[i]) begin
        if (qn[i] > lo) lo = qn[i];
        if (qf[i] < hi) hi = qf[i];
      end
    end
    ok = !sd.par_fail && (lo <= hi);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (en) begin
      res.valid <= vld[DIV_LAT];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.hit    <= ok;
      res.t_near <= ok ? lo : '0;
      res.t_far  <= ok ? hi : '0;
    end
  end

endmodule

// ===== rtl/core/rbs_div.sv =====
`timescale 1ns / 1ps
module rbs_div (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [rbs_pkg::NUM_W-1:0]    num,
  input  logic signed [rbs_pkg::Q_W-1:0]      den,
  output logic signed [rbs_pkg::Q_W-1:0]      q
);
  import rbs_pkg::*;

  localparam int MAG_W = NUM_W + 16;
  localparam int CMP_W = 2 * Q_W;

  logic [NUM_W-1:0] n_abs;
  logic [Q_W-1:0]   d_abs;

  logic [MAG_W-1:0] rem  [0:Q_W];
  logic [Q_W-1:0]   dm   [0:Q_W];
  logic [Q_W-1:0]   qb   [0:Q_W];
  logic             neg  [0:Q_W];
  logic             ovf  [0:Q_W];

  logic [CMP_W-1:0] sub  [0:Q_W-1];
  logic             ge   [0:Q_W-1];

  always_comb begin
    n_abs = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    d_abs = den[Q_W-1] ? Q_W'(-den) : Q_W'(den);
  end

  always_comb begin
    for (int s = 0; s < Q_W; s++) begin
      sub[s] = {{Q_W{1'b0}}, dm[s]} << (Q_W - 1 - s);
      ge[s]  = {{(CMP_W-MAG_W){1'b0}}, rem[s]} >= sub[s];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= {n_abs, 16'b0};
      dm[0]  <= d_abs;
      qb[0]  <= '0;
      neg[0] <= num[NUM_W-1] ^ den[Q_W-1];
      // quotient of 2^32 or more: saturate regardless of sign
      ovf[0] <= {{(CMP_W-MAG_W){1'b0}}, n_abs, 16'b0} >= {d_abs, {Q_W{1'b0}}};
      for (int s = 0; s < Q_W; s++) begin
        rem[s+1] <= ge[s] ? rem[s] - sub[s][MAG_W-1:0] : rem[s];
        qb[s+1]  <= qb[s] | (ge[s] ? (Q_W'(1) << (Q_W - 1 - s)) : '0);
        dm[s+1]  <= dm[s];
        neg[s+1] <= neg[s];
        ovf[s+1] <= ovf[s];
      end
      if (!neg[Q_W]) begin
        q <= (ovf[Q_W] || qb[Q_W][Q_W-1]) ? T_MAX : $signed(qb[Q_W]);
      end else begin
        q <= (ovf[Q_W] || qb[Q_W] > {1'b1, {(Q_W-1){1'b0}}}) ? T_MIN
             : $signed(Q_W'(-qb[Q_W]));
      end
    end
  end

endmodule
